/* sv/wvc_pkg.sv */
// ----------------------------------------------------------------------------
// wvc_pkg: shared types and constants of the waypoint velocity controller
// Register map codes, controller/datapath interface structs, CORDIC table.
// ----------------------------------------------------------------------------
package wvc_pkg;

	// Datapath widths
	localparam int DW = 33;            // position difference, signed
	localparam int XW = 45;            // CORDIC x/y, signed, normalized to 2^40
	localparam int ZW = 24;            // CORDIC angle, 2^-24 turn
	localparam int SW = 35;            // square root remainder/root
	localparam int STEP_W = 5;

	// Sequencing
	localparam int CORDIC_STEPS = 18;
	localparam int ITER_STEPS   = 20;  // squares take the first three slots
	localparam int SQRT_START   = 3;
	localparam int NORM_BIT     = 40;
	localparam int COARSE_BIT   = 32;

	localparam logic [ZW-1:0] HALF_TURN = 24'h800000;
	localparam logic [ZW-1:0] Z_ROUND   = 24'h000080;
	localparam logic [SW-1:0] SQRT_TOP  = 35'h100000000;
	localparam logic [16:0]   FAR_DIST  = 17'h10000;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_POS_TOL  = 2'd0;
	localparam logic [1:0] REG_HEAD_TOL = 2'd1;
	localparam logic [1:0] REG_MAX_LIN  = 2'd2;
	localparam logic [1:0] REG_MAX_TURN = 2'd3;

	// Input command codes
	localparam logic CMD_COMPUTE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	typedef struct packed {
		logic [15:0] pos_tol;
		logic [14:0] head_tol;
		logic [15:0] max_lin;
		logic [14:0] max_turn;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic              setup;
		logic              norm;
		logic              iter;
		logic [STEP_W-1:0] step;
		logic              write;
	} dp_cmd_t;

	typedef struct packed {
		logic norm_done;
		logic clear;
	} dp_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_NORM  = 5'b00100,
		ST_ITER  = 5'b01000,
		ST_FINAL = 5'b10000
	} state_t;

	// atan(2^-i) in units of 2^-24 turn
	function automatic logic [ZW-1:0] atan_val(input logic [STEP_W-1:0] i);
		logic [ZW-1:0] v;
		case (i)
			5'd0:    v = 24'd2097152;
			5'd1:    v = 24'd1238021;
			5'd2:    v = 24'd654136;
			5'd3:    v = 24'd332050;
			5'd4:    v = 24'd166669;
			5'd5:    v = 24'd83416;
			5'd6:    v = 24'd41718;
			5'd7:    v = 24'd20860;
			5'd8:    v = 24'd10430;
			5'd9:    v = 24'd5215;
			5'd10:   v = 24'd2608;
			5'd11:   v = 24'd1304;
			5'd12:   v = 24'd652;
			5'd13:   v = 24'd326;
			5'd14:   v = 24'd163;
			5'd15:   v = 24'd81;
			5'd16:   v = 24'd41;
			5'd17:   v = 24'd20;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* sv/waypoint_velocity_controller_top.sv */
// ----------------------------------------------------------------------------
// waypoint_velocity_controller_top: unicycle go-to-goal velocity controller
// Turns robot and waypoint poses into angular and linear speed commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one transaction per pose pair; s_tuser is the command
//   (0 compute, 1 clear the arrival flag for a new path).
//   Master stream m_*: exactly one result transaction per input transaction,
//   in order.
//   APB port: four registers at byte addresses 0, 4, 8, 12 (position
//   tolerance, heading tolerance, max linear speed, max turn rate).
// Sequencing:
//   A compute transaction runs from acceptance through a setup step, a
//   normalization phase (shifts by 8 or by 1 until the larger component
//   reaches 2^40, plus a check that sees it; it ends at once when robot and
//   waypoint coincide), an iteration phase (18 CORDIC micro-rotations; the
//   squarer and a 17-step square root run alongside) and a result step. A
//   clear transaction goes from setup straight to the result step.
//   One item is in flight at a time; s_tready is high only while idle.
// Reset and stalls:
//   Reset restores the register defaults and clears the arrival flag. A
//   result waiting on m_tready holds; the next input is still accepted and
//   processed, and its result waits until the output register is free.
// ----------------------------------------------------------------------------
module waypoint_velocity_controller_top (
	input  logic         clk,
	input  logic         arst_n,
	// command
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic         s_tuser,
	// robot_x, robot_y, robot_heading, goal_x, goal_y, goal_heading
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// turn_rate, forward_speed, arrived, zero pad
	output logic [39:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	wvc_pkg::cfg_t     cfg;
	wvc_pkg::dp_cmd_t  cmd;
	wvc_pkg::dp_stat_t stat;
	logic [15:0]       turn_rate;
	logic [15:0]       forward_speed;
	logic              arrived;

	wvc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wvc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg           (cfg),
		.command       (s_tuser),
		.robot_x       (s_tdata[31:0]),
		.robot_y       (s_tdata[63:32]),
		.robot_heading (s_tdata[79:64]),
		.goal_x        (s_tdata[111:80]),
		.goal_y        (s_tdata[143:112]),
		.goal_heading  (s_tdata[159:144]),
		.turn_rate     (turn_rate),
		.forward_speed (forward_speed),
		.arrived       (arrived)
	);

	assign m_tdata = {7'd0, arrived, forward_speed, turn_rate};

endmodule

/* sv/wvc_regs.sv */
// ----------------------------------------------------------------------------
// wvc_regs: configuration register file
// APB-style write/read of the four tolerance and limit registers.
// ----------------------------------------------------------------------------
module wvc_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output wvc_pkg::cfg_t       cfg
);

	wvc_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// register writes, unused bits masked off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_tol  <= 16'd655;
			cfg_q.head_tol <= 15'd104;
			cfg_q.max_lin  <= 16'd6554;
			cfg_q.max_turn <= 15'd20861;
		end else if (wr_en) begin
			case (paddr[3:2])
				wvc_pkg::REG_POS_TOL:  cfg_q.pos_tol  <= pwdata[15:0];
				wvc_pkg::REG_HEAD_TOL: cfg_q.head_tol <= pwdata[14:0];
				wvc_pkg::REG_MAX_LIN:  cfg_q.max_lin  <= pwdata[15:0];
				wvc_pkg::REG_MAX_TURN: cfg_q.max_turn <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[3:2])
			wvc_pkg::REG_POS_TOL:  prdata = {16'd0, cfg_q.pos_tol};
			wvc_pkg::REG_HEAD_TOL: prdata = {17'd0, cfg_q.head_tol};
			wvc_pkg::REG_MAX_LIN:  prdata = {16'd0, cfg_q.max_lin};
			wvc_pkg::REG_MAX_TURN: prdata = {17'd0, cfg_q.max_turn};
			default:               prdata = '0;
		endcase
	end

endmodule

/* sv/wvc_ctrl.sv */
// ----------------------------------------------------------------------------
// wvc_ctrl: sequencing state machine
// Steps the datapath through setup, normalization, CORDIC/sqrt iterations and
// the final result write; owns the output valid flag.
// ----------------------------------------------------------------------------
module wvc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  wvc_pkg::dp_stat_t   stat,
	output wvc_pkg::dp_cmd_t    cmd
);

	wvc_pkg::state_t                 state_q;
	logic [wvc_pkg::STEP_W-1:0]      step_q;
	logic                            out_valid_q;
	logic                            accept;
	logic                            write;

	assign s_tready = (state_q == wvc_pkg::ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign write    = (state_q == wvc_pkg::ST_FINAL) & (~out_valid_q | m_tready);
	assign m_tvalid = out_valid_q;

	// datapath commands
	always_comb begin
		cmd.load  = accept;
		cmd.setup = (state_q == wvc_pkg::ST_SETUP);
		cmd.norm  = (state_q == wvc_pkg::ST_NORM);
		cmd.iter  = (state_q == wvc_pkg::ST_ITER);
		cmd.step  = step_q;
		cmd.write = write;
	end

	// state sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wvc_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				wvc_pkg::ST_IDLE: begin
					if (accept) state_q <= wvc_pkg::ST_SETUP;
				end
				wvc_pkg::ST_SETUP: begin
					// a clear transaction goes straight to the result
					state_q <= stat.clear ? wvc_pkg::ST_FINAL : wvc_pkg::ST_NORM;
				end
				wvc_pkg::ST_NORM: begin
					if (stat.norm_done) begin
						state_q <= wvc_pkg::ST_ITER;
						step_q  <= '0;
					end
				end
				wvc_pkg::ST_ITER: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(wvc_pkg::ITER_STEPS - 1)) state_q <= wvc_pkg::ST_FINAL;
				end
				wvc_pkg::ST_FINAL: begin
					if (write) state_q <= wvc_pkg::ST_IDLE;
				end
				default: state_q <= wvc_pkg::ST_IDLE;
			endcase
		end
	end

	// output valid: set on result write, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* sv/wvc_dp.sv */
// ----------------------------------------------------------------------------
// wvc_dp: controller datapath
// Position difference, CORDIC vectoring for the bearing, shared squarer and
// bit-serial square root for the distance, and the command/limit logic.
// ----------------------------------------------------------------------------
module wvc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wvc_pkg::dp_cmd_t     cmd,
	output wvc_pkg::dp_stat_t    stat,
	input  wvc_pkg::cfg_t        cfg,
	input  logic                 command,
	input  logic signed [31:0]   robot_x,
	input  logic signed [31:0]   robot_y,
	input  logic signed [15:0]   robot_heading,
	input  logic signed [31:0]   goal_x,
	input  logic signed [31:0]   goal_y,
	input  logic signed [15:0]   goal_heading,
	output logic signed [15:0]   turn_rate,
	output logic [15:0]          forward_speed,
	output logic                 arrived
);

	localparam int DW = wvc_pkg::DW;
	localparam int XW = wvc_pkg::XW;
	localparam int ZW = wvc_pkg::ZW;
	localparam int SW = wvc_pkg::SW;

	function automatic logic [16:0] abs17(input logic [15:0] v);
		logic [16:0] e;
		e = {v[15], v};
		return v[15] ? (~e + 17'd1) : e;
	endfunction

	// transaction registers
	logic                 cmd_q;
	logic [15:0]          rh_q, gh_q;
	logic signed [DW-1:0] dx_q, dy_q;
	// CORDIC state
	logic signed [XW-1:0] x_q, y_q;
	logic [ZW-1:0]        z_q;
	logic                 zero_q;
	// distance state
	logic                 far_q;
	logic [15:0]          adx_q, ady_q;
	logic [31:0]          p_q;
	logic [SW-1:0]        n_q, r_q, bit_q;
	// sticky arrival flag
	logic                 flag_q;
	// result registers
	logic [15:0]          turn_q, speed_q;
	logic                 arrived_q;

	// setup values
	logic [DW-1:0]        adx_full, ady_full;
	logic signed [XW-1:0] dxe, dye;
	// normalization
	logic [XW-1:0]        ax, ay;
	logic                 coarse, norm_done;
	// CORDIC step
	logic signed [XW-1:0] xs, ys;
	logic                 y_pos;
	logic                 cordic_en, sqrt_en;
	logic [15:0]          mul_a;
	logic [SW-1:0]        trial;
	// result logic
	logic [ZW-1:0]        zr;
	logic [15:0]          bear, err, hdiff, ang1, ang2, ang, ang_sat;
	logic [16:0]          aerr, ahd, aang, distance, dist_cut;
	logic                 hit;
	logic [15:0]          lin;

	assign adx_full = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
	assign ady_full = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
	assign dxe      = {{(XW-DW){dx_q[DW-1]}}, dx_q};
	assign dye      = {{(XW-DW){dy_q[DW-1]}}, dy_q};

	// normalization status: shifting up until the larger magnitude reaches 2^40
	assign ax        = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
	assign ay        = y_q[XW-1] ? XW'(-y_q) : XW'(y_q);
	assign coarse    = (ax[XW-1:wvc_pkg::COARSE_BIT] == '0) && (ay[XW-1:wvc_pkg::COARSE_BIT] == '0);
	assign norm_done = zero_q || (ax[XW-1:wvc_pkg::NORM_BIT] != '0)
	                          || (ay[XW-1:wvc_pkg::NORM_BIT] != '0);

	assign stat.norm_done = norm_done;
	assign stat.clear     = cmd_q;

	// iteration helpers
	assign xs        = x_q >>> cmd.step;
	assign ys        = y_q >>> cmd.step;
	assign y_pos     = !y_q[XW-1] && (y_q != '0);
	assign cordic_en = cmd.iter && (cmd.step < 5'(wvc_pkg::CORDIC_STEPS));
	assign sqrt_en   = cmd.iter && (cmd.step >= 5'(wvc_pkg::SQRT_START));
	assign mul_a     = (cmd.step == 5'd0) ? adx_q : ady_q;
	assign trial     = r_q + bit_q;

	// input capture and position difference
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			rh_q  <= robot_heading;
			gh_q  <= goal_heading;
			dx_q  <= DW'({goal_x[31], goal_x}) - DW'({robot_x[31], robot_x});
			dy_q  <= DW'({goal_y[31], goal_y}) - DW'({robot_y[31], robot_y});
		end
	end

	// CORDIC: half-turn fold, normalization, micro-rotations
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			zero_q <= (dx_q == '0) && (dy_q == '0);
			if (dx_q[DW-1]) begin
				x_q <= -dxe;
				y_q <= -dye;
				z_q <= wvc_pkg::HALF_TURN;
			end else begin
				x_q <= dxe;
				y_q <= dye;
				z_q <= '0;
			end
		end else if (cmd.norm && !norm_done) begin
			if (coarse) begin
				x_q <= x_q <<< 8;
				y_q <= y_q <<< 8;
			end else begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
			end
		end else if (cordic_en) begin
			if (y_pos) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + wvc_pkg::atan_val(cmd.step);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - wvc_pkg::atan_val(cmd.step);
			end
		end
	end

	// distance: squares through one multiplier, then restoring square root
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			far_q <= (adx_full[DW-1:16] != '0) || (ady_full[DW-1:16] != '0);
			adx_q <= adx_full[15:0];
			ady_q <= ady_full[15:0];
			r_q   <= '0;
			bit_q <= wvc_pkg::SQRT_TOP;
		end else if (cmd.iter) begin
			if (cmd.step < 5'd2) p_q <= {16'd0, mul_a} * {16'd0, mul_a};
			if (cmd.step == 5'd1) n_q <= SW'(p_q);
			if (cmd.step == 5'd2) n_q <= n_q + SW'(p_q);
			if (sqrt_en) begin
				if (n_q >= trial) begin
					n_q <= n_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	// command law from bearing, distance and limits
	always_comb begin
		zr    = z_q + wvc_pkg::Z_ROUND;
		bear  = zero_q ? 16'd0 : zr[ZW-1:8];
		err   = bear - rh_q;
		aerr  = abs17(err);
		ang1  = (aerr <= {2'b00, cfg.head_tol}) ? 16'd0 : err;
		hdiff = gh_q - rh_q;
		ahd   = abs17(hdiff);
		ang2  = (ahd <= {2'b00, cfg.head_tol}) ? 16'd0 : hdiff;
		ang   = flag_q ? ang2 : ang1;
		aang  = abs17(ang);
		if (aang > {2'b00, cfg.max_turn})
			ang_sat = ang[15] ? 16'(-{1'b0, cfg.max_turn}) : {1'b0, cfg.max_turn};
		else
			ang_sat = ang;
		distance = far_q ? wvc_pkg::FAR_DIST : r_q[16:0];
		hit      = distance <= {1'b0, cfg.pos_tol};
		dist_cut = hit ? 17'd0 : distance;
		if (aerr < {2'b00, cfg.head_tol})
			lin = (dist_cut < {1'b0, cfg.max_lin}) ? dist_cut[15:0] : cfg.max_lin;
		else
			lin = 16'd0;
	end

	// arrival flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (cmd.write) begin
			flag_q <= (cmd_q == wvc_pkg::CMD_CLEAR) ? 1'b0 : (flag_q | hit);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			if (cmd_q == wvc_pkg::CMD_CLEAR) begin
				turn_q    <= '0;
				speed_q   <= '0;
				arrived_q <= 1'b0;
			end else begin
				turn_q    <= ang_sat;
				speed_q   <= lin;
				arrived_q <= flag_q | hit;
			end
		end
	end

	assign turn_rate     = turn_q;
	assign forward_speed = speed_q;
	assign arrived       = arrived_q;

endmodule

/* sv/wvc_checker.sv */
// ----------------------------------------------------------------------------
// wvc_checker: port-level checks for the waypoint velocity controller
// Watches the stream and APB ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module wvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        pready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one transaction in flight: busy right after an accepted input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// turn rate stays within the symmetric 15-bit limit; pad bits are zero
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[39:33] == 7'd0))
		else $error("turn rate out of range or pad bits set");

	// configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind waypoint_velocity_controller_top wvc_checker u_wvc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);

/* dv/waypoint_velocity_controller_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_velocity_controller_checker: scoreboard of the velocity controller
// Tracks the register writes on the APB port and the arrival flag, predicts
// the steering command of every accepted pose transaction and compares each
// result transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module waypoint_velocity_controller_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// command
	input  logic         s_tuser,
	// robot_x, robot_y, robot_heading, goal_x, goal_y, goal_heading
	input  logic [159:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// turn_rate, forward_speed, arrived, zero pad
	input  logic [39:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           fails,
	output int           steers_owed
);

	localparam logic [15:0] POS_TOL_RST  = 16'd655;
	localparam logic [14:0] HEAD_TOL_RST = 15'd104;
	localparam logic [15:0] MAX_LIN_RST  = 16'd6554;
	localparam logic [14:0] MAX_TURN_RST = 15'd20861;
	localparam int          ROTATIONS    = 18;
	localparam longint      NORM_FLOOR   = 64'sd1 << 40;
	localparam logic [31:0] HALF_TURN_Z  = 32'h0080_0000;
	localparam logic [16:0] FAR_AWAY     = 17'h10000;

	typedef struct packed {
		logic        cmd;
		logic [31:0] robot_x;
		logic [31:0] robot_y;
		logic [15:0] robot_heading;
		logic [31:0] goal_x;
		logic [31:0] goal_y;
		logic [15:0] goal_heading;
	} pose_t;

	typedef struct packed {
		logic [15:0] turn_rate;
		logic [15:0] forward_speed;
		logic        arrived;
	} steer_t;

	wvc_pkg::cfg_t limits;
	logic          at_goal;
	steer_t        steer_fifo[$];
	int            mismatches = 0;

	// arctan(2^-i) in 2^-24 turn
	function automatic logic [31:0] arctan_step(input int i);
		case (i)
			0:       return 32'd2097152;
			1:       return 32'd1238021;
			2:       return 32'd654136;
			3:       return 32'd332050;
			4:       return 32'd166669;
			5:       return 32'd83416;
			6:       return 32'd41718;
			7:       return 32'd20860;
			8:       return 32'd10430;
			9:       return 32'd5215;
			10:      return 32'd2608;
			11:      return 32'd1304;
			12:      return 32'd652;
			13:      return 32'd326;
			14:      return 32'd163;
			15:      return 32'd81;
			16:      return 32'd41;
			17:      return 32'd20;
			default: return 32'd0;
		endcase
	endfunction

	function automatic int mag_of(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint mag_of_l(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// CORDIC vectoring, bearing as a 16-bit binary angle
	function automatic logic [15:0] bearing_of(input longint dx, input longint dy);
		longint      x, y, nx, ny, m;
		logic [31:0] z;
		int          i;
		if (dx == 0 && dy == 0)
			return 16'd0;
		x = dx;
		y = dy;
		z = '0;
		// left half plane: rotate by a half turn first
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_TURN_Z;
		end
		m = (x > mag_of_l(y)) ? x : mag_of_l(y);
		while (m < NORM_FLOOR) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		for (i = 0; i < ROTATIONS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z  = z + arctan_step(i);
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z  = z - arctan_step(i);
			end
			x = nx;
			y = ny;
		end
		z = (z + 32'd128) >> 8;
		return z[15:0];
	endfunction

	// floor of the square root, argument below 2^34
	function automatic logic [16:0] floor_sqrt(input longint n);
		logic [16:0] r;
		longint      t;
		int          b;
		r = '0;
		for (b = 16; b >= 0; b--) begin
			t = longint'(r | (17'd1 << b));
			if (t * t <= n)
				r = r | (17'd1 << b);
		end
		return r;
	endfunction

	// go-to-goal law for one pose transaction
	function automatic steer_t predict_steer(input pose_t p, input wvc_pkg::cfg_t c,
						input logic was_arrived);
		steer_t             res;
		longint             dx, dy, adx, ady;
		logic signed [15:0] err, turn16;
		logic [16:0]        distance;
		int                 e_mag, turn, tol_h, turn_max;
		res      = '0;
		tol_h    = int'(c.head_tol);
		turn_max = int'(c.max_turn);
		if (p.cmd == wvc_pkg::CMD_CLEAR)
			return res;
		dx = longint'($signed(p.goal_x)) - longint'($signed(p.robot_x));
		dy = longint'($signed(p.goal_y)) - longint'($signed(p.robot_y));

		// heading error wraps at 16 bits
		err   = bearing_of(dx, dy) - p.robot_heading;
		e_mag = mag_of(int'(err));
		turn  = int'(err);
		if (e_mag <= tol_h)
			turn = 0;
		// once arrived, line up with the waypoint's own heading
		if (was_arrived) begin
			turn16 = p.goal_heading - p.robot_heading;
			turn   = int'(turn16);
			if (mag_of(turn) <= tol_h)
				turn = 0;
		end
		if (mag_of(turn) > turn_max)
			turn = (turn < 0) ? -turn_max : turn_max;
		res.turn_rate = 16'(turn);

		// distance, saturated far away
		adx = mag_of_l(dx);
		ady = mag_of_l(dy);
		if (adx > 65535 || ady > 65535)
			distance = FAR_AWAY;
		else
			distance = floor_sqrt(adx * adx + ady * ady);
		res.arrived = was_arrived;
		if (distance <= {1'b0, c.pos_tol}) begin
			distance    = '0;
			res.arrived = 1'b1;
		end
		if (e_mag < tol_h)
			res.forward_speed = (distance < {1'b0, c.max_lin}) ? distance[15:0] : c.max_lin;
		else
			res.forward_speed = '0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		steer_t want, seen;
		pose_t  pose;
		if (!arst_n) begin
			limits.pos_tol  <= POS_TOL_RST;
			limits.head_tol <= HEAD_TOL_RST;
			limits.max_lin  <= MAX_LIN_RST;
			limits.max_turn <= MAX_TURN_RST;
			at_goal         <= 1'b0;
			steer_fifo.delete();
			steers_owed     <= 0;
			fails           <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					wvc_pkg::REG_POS_TOL:  limits.pos_tol  <= pwdata[15:0];
					wvc_pkg::REG_HEAD_TOL: limits.head_tol <= pwdata[14:0];
					wvc_pkg::REG_MAX_LIN:  limits.max_lin  <= pwdata[15:0];
					wvc_pkg::REG_MAX_TURN: limits.max_turn <= pwdata[14:0];
					default: ;
				endcase
			end

			// result transaction against the oldest prediction
			if (m_tvalid && m_tready) begin
				seen.turn_rate     = m_tdata[15:0];
				seen.forward_speed = m_tdata[31:16];
				seen.arrived       = m_tdata[32];
				if (steer_fifo.size() == 0) begin
					$error("result with no pending command: turn_rate %0d forward_speed %0d",
						$signed(seen.turn_rate), seen.forward_speed);
					mismatches++;
				end else begin
					want = steer_fifo.pop_front();
					if (seen.turn_rate !== want.turn_rate) begin
						$error("turn_rate mismatch: expected %0d, got %0d",
							$signed(want.turn_rate), $signed(seen.turn_rate));
						mismatches++;
					end
					if (seen.forward_speed !== want.forward_speed) begin
						$error("forward_speed mismatch: expected %0d, got %0d",
							want.forward_speed, seen.forward_speed);
						mismatches++;
					end
					if (seen.arrived !== want.arrived) begin
						$error("arrived mismatch: expected %0d, got %0d",
							want.arrived, seen.arrived);
						mismatches++;
					end
				end
			end

			// pose transaction: predict and advance the arrival flag
			if (s_tvalid && s_tready) begin
				pose.cmd           = s_tuser;
				pose.robot_x       = s_tdata[31:0];
				pose.robot_y       = s_tdata[63:32];
				pose.robot_heading = s_tdata[79:64];
				pose.goal_x        = s_tdata[111:80];
				pose.goal_y        = s_tdata[143:112];
				pose.goal_heading  = s_tdata[159:144];
				want = predict_steer(pose, limits, at_goal);
				steer_fifo.insert(steer_fifo.size(), want);
				at_goal <= want.arrived;
			end

			steers_owed <= steer_fifo.size();
			fails       <= mismatches;
		end
	end

endmodule

/* dv/waypoint_velocity_controller_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_velocity_controller_top_tb: testbench of the velocity controller
// Drives directed and random pose transactions through several register
// settings and idle patterns; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module waypoint_velocity_controller_top_tb;

	localparam int STALL_LIMIT     = 2000;
	localparam int PHASES          = 8;
	localparam int POSES_PER_PHASE = 50;
	localparam int SETTLE_CYCLES   = 40;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic         s_tuser  = wvc_pkg::CMD_COMPUTE;
	logic [159:0] s_tdata  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b1;
	logic [39:0]  m_tdata;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [3:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;

	int fails;
	int steers_owed;
	int snd_idle_pct  = 0;
	int rcv_stall_pct = 0;
	int quiet_cycles  = 0;

	waypoint_velocity_controller_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	waypoint_velocity_controller_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fails(fails), .steers_owed(steers_owed)
	);

	always #6 clk = ~clk;

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// watchdog: cycles with no transaction on any port
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// one pose transaction; called and returns at a falling edge
	task automatic send_pose(input logic cmd,
				input logic [31:0] rx, input logic [31:0] ry, input logic [15:0] rh,
				input logic [31:0] gx, input logic [31:0] gy, input logic [15:0] gh);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {gh, gy, gx, rh, ry, rx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// register write, setup then access; bits above the field are random
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val,
				input logic [31:0] field_mask);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = ($urandom() & ~field_mask) | (val & field_mask);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (steers_owed != 0)
			@(negedge clk);
	endtask

	// mostly approaches towards a random waypoint, some clears and noise
	task automatic random_pose();
		logic [31:0] gx, gy, rx, ry, ox, oy;
		logic [15:0] rh, gh, aim;
		int          span, reach;
		gx = $urandom();
		gy = $urandom();
		gh = 16'($urandom());
		rh = 16'($urandom());
		if ($urandom_range(99) < 8) begin
			send_pose(wvc_pkg::CMD_CLEAR, $urandom(), $urandom(), rh, gx, gy, gh);
		end else begin
			case ($urandom_range(3))
				0:       span = 1023;
				1:       span = 70000;
				default: span = 1 << 20;
			endcase
			reach = $urandom_range(span);
			aim   = 16'($urandom());
			case ($urandom_range(5))
				0: begin
					ox = int'($urandom_range(2 * span)) - span;
					oy = int'($urandom_range(2 * span)) - span;
				end
				1: begin ox = reach;  oy = 0;     aim = 16'd0;     end
				2: begin ox = 0;      oy = reach; aim = 16'd16384; end
				3: begin ox = -reach; oy = 0;     aim = 16'h8000;  end
				4: begin ox = reach;  oy = reach; aim = 16'd8192;  end
				default: begin
					ox = $urandom();
					oy = $urandom();
				end
			endcase
			rx = gx - ox;
			ry = gy - oy;
			if ($urandom_range(1))
				rh = aim + 16'($urandom_range(600)) - 16'd300;
			if ($urandom_range(2) == 0)
				gh = rh + 16'($urandom_range(600)) - 16'd300;
			send_pose(wvc_pkg::CMD_COMPUTE, rx, ry, rh, gx, gy, gh);
		end
	endtask

	initial begin
		logic [15:0] pos_tol, max_lin;
		logic [14:0] head_tol, max_turn;
		int          phase, n;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, reset register values
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'd0, 0, 0, 16'd0);             // on the spot
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'd0, 1000, 0, 16'h8000);        // arrived, half turn
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'h8000, 0, 0, 16'h7fff);        // arrived, wrap
		send_pose(wvc_pkg::CMD_CLEAR, '1, '1, '1, '1, '1, '1);
		send_pose(wvc_pkg::CMD_COMPUTE, 32'h8000_0000, 0, 16'd0, 32'h7fff_ffff, 0, 16'd0);
		send_pose(wvc_pkg::CMD_COMPUTE, 32'h7fff_ffff, 0, 16'd0, 32'h8000_0000, 0, 16'd0);
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 32'h8000_0000, 16'd16384, 0, 32'h7fff_ffff,
			16'h8000);
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 32'h7fff_ffff, 16'hc000, 0, 32'h8000_0000,
			16'h7fff);
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'd0, 656, 0, 16'd0);            // just outside
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'd0, 655, 0, 16'd0);            // on the tolerance
		send_pose(wvc_pkg::CMD_CLEAR, 0, 0, 16'd0, 0, 0, 16'd0);
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, -16'sd104, 100000, 0, 16'd0);     // error at tolerance
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, -16'sd103, 100000, 0, 16'd0);
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, -16'sd105, 100000, 0, 16'd0);
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'h7fff, 100000, 0, 16'd0);
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'd8192, 65535, 65535, 16'd0);   // largest finite
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'd0, 65536, -1, 16'd0);         // just too far
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'h8000, -65535, 0, 16'd0);
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'd0, 0, -5, 16'd0);
		send_pose(wvc_pkg::CMD_COMPUTE, 32'h8000_0000, 32'h7fff_ffff, 16'd4000,
			32'h8000_0000, 32'h7fff_ffff, 16'd4104);                        // arrives
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'd4000, 0, 0, 16'd4105);
		send_pose(wvc_pkg::CMD_COMPUTE, 0, 0, 16'd4000, 0, 0, 16'd36768);
		send_pose(wvc_pkg::CMD_CLEAR, $urandom(), $urandom(), 16'h5a5a, $urandom(), $urandom(),
			16'ha5a5);
		wait_drained();

		// random phases under changing limits and idle patterns
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				case (phase)
					1: begin
						pos_tol = 16'hffff; head_tol = 15'h7fff;
						max_lin = 16'hffff; max_turn = 15'h7fff;
					end
					2: begin
						pos_tol = '0; head_tol = '0; max_lin = '0; max_turn = '0;
					end
					3: begin
						pos_tol = 16'd1; head_tol = 15'd1; max_lin = 16'd1; max_turn = 15'd1;
					end
					default: begin
						pos_tol  = 16'($urandom_range(4000));
						head_tol = 15'($urandom_range(1500));
						max_lin  = 16'($urandom_range(65535));
						max_turn = 15'($urandom_range(32767));
					end
				endcase
				write_reg(wvc_pkg::REG_POS_TOL, {16'd0, pos_tol}, 32'h0000_ffff);
				write_reg(wvc_pkg::REG_HEAD_TOL, {17'd0, head_tol}, 32'h0000_7fff);
				write_reg(wvc_pkg::REG_MAX_LIN, {16'd0, max_lin}, 32'h0000_ffff);
				write_reg(wvc_pkg::REG_MAX_TURN, {17'd0, max_turn}, 32'h0000_7fff);
			end
			case (phase % 4)
				0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1:       begin snd_idle_pct = 85; rcv_stall_pct = 0;  end
				2:       begin snd_idle_pct = 0;  rcv_stall_pct = 85; end
				default: begin snd_idle_pct = 34; rcv_stall_pct = 34; end
			endcase
			for (n = 0; n < POSES_PER_PHASE; n++)
				random_pose();
			wait_drained();
		end

		rcv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fails == 0 && steers_owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
sv/wvc_pkg.sv
sv/wvc_regs.sv
sv/wvc_ctrl.sv
sv/wvc_dp.sv
sv/waypoint_velocity_controller_top.sv
sv/wvc_checker.sv
dv/waypoint_velocity_controller_checker.sv
dv/waypoint_velocity_controller_top_tb.sv
